// ===== src/msc_pkg.sv =====
`timescale 1ns / 1ps

package msc_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_PUSH  = 2'd1,
		OP_POP   = 2'd2,
		OP_PEEK  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COUNT,
		ST_RESULT
	} state_t;

	localparam int FIELD_W = 16;
	localparam int ID_W    = 7;

endpackage

// ===== src/msc_ram.sv =====
`timescale 1ns / 1ps

module msc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/multi_stack_coordinate_store.sv =====
// A result passes through the count RAM read (registered at the transfer edge), the entry
// RAM read and the output register; a stalled output holds it back in the last step.
// No new item is taken until the previous one has run the count RAM read and the entry RAM read
// in sequence and its result has been loaded into the output register.
// Reset: a clearing pass over all NUM_STACKS stacks writes every stack count to zero; no item is
// taken during it. Stored entries stay undefined until pushed.
`timescale 1ns / 1ps

module multi_stack_coordinate_store #(
	parameter int NUM_STACKS  = 128,
	parameter int STACK_DEPTH = 128,
	parameter int COORD_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [6:0]  stack_id,
	input  logic [15:0] in_x,
	input  logic [15:0] in_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] out_x,
	output logic [15:0] out_y,
	output logic        done_res,
	output logic        now_empty
);

	localparam int IW     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam int DW     = $clog2(STACK_DEPTH);
	localparam int CW     = $clog2(STACK_DEPTH + 1);
	localparam int SW     = (COORD_WIDTH < msc_pkg::FIELD_W) ? COORD_WIDTH : msc_pkg::FIELD_W;
	localparam int EAW    = IW + DW;
	localparam int EDEPTH = NUM_STACKS * (1 << DW);

	msc_pkg::state_t state_q, state_nxt;

	logic [IW-1:0]   clr_idx_q;
	msc_pkg::op_t    func_q;
	logic [IW-1:0]   id_q;
	logic            id_ok_q;
	logic [SW-1:0]   x_q;
	logic [SW-1:0]   y_q;
	logic            res_done_q;
	logic            res_empty_q;
	logic            res_rd_q;

	logic            out_valid_q;
	logic [15:0]     out_x_q;
	logic [15:0]     out_y_q;
	logic            done_q;
	logic            empty_q;

	logic            accept;
	logic            id_ok;
	logic            out_load;

	logic            cnt_we;
	logic [IW-1:0]   cnt_waddr;
	logic [CW-1:0]   cnt_wdata;
	logic            cnt_re;
	logic [CW-1:0]   cnt_rdata;

	logic            ent_we;
	logic            ent_re;
	logic [DW-1:0]   ent_ptr;
	logic [2*SW-1:0] ent_rdata;

	logic [CW-1:0]   cnt_new;
	logic            res_done;

	assign id_ok    = (32'(stack_id) < NUM_STACKS);
	assign accept   = in_valid && !in_stall;
	assign out_load = !out_valid_q || !out_stall;

	msc_ram #(
		.WIDTH(CW),
		.DEPTH(NUM_STACKS),
		.AW   (IW)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.re   (cnt_re),
		.raddr(IW'(stack_id)),
		.rdata(cnt_rdata)
	);

	msc_ram #(
		.WIDTH(2 * SW),
		.DEPTH(EDEPTH),
		.AW   (EAW)
	) u_ent_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr({id_q, ent_ptr}),
		.wdata({y_q, x_q}),
		.re   (ent_re),
		.raddr({id_q, ent_ptr}),
		.rdata(ent_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_stall  = 1'b1;
		cnt_re    = 1'b0;
		cnt_we    = 1'b0;
		cnt_waddr = id_q;
		cnt_wdata = '0;
		ent_we    = 1'b0;
		ent_re    = 1'b0;
		ent_ptr   = DW'(cnt_rdata);
		cnt_new   = cnt_rdata;
		res_done  = 1'b0;
		case (state_q)
			msc_pkg::ST_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_idx_q;
				if (clr_idx_q == IW'(NUM_STACKS - 1)) begin
					state_nxt = msc_pkg::ST_IDLE;
				end
			end
			msc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cnt_re   = in_valid && id_ok;
				if (in_valid) begin
					state_nxt = msc_pkg::ST_COUNT;
				end
			end
			msc_pkg::ST_COUNT: begin
				state_nxt = msc_pkg::ST_RESULT;
				if (id_ok_q) begin
					case (func_q)
						msc_pkg::OP_CLEAR: begin
							cnt_new  = '0;
							res_done = 1'b1;
						end
						msc_pkg::OP_PUSH: begin
							if (cnt_rdata != CW'(STACK_DEPTH)) begin
								ent_we   = 1'b1;
								cnt_new  = cnt_rdata + CW'(1);
								res_done = 1'b1;
							end
						end
						default: begin
							if (cnt_rdata != '0) begin
								ent_re   = 1'b1;
								ent_ptr  = DW'(cnt_rdata - CW'(1));
								res_done = 1'b1;
								if (func_q == msc_pkg::OP_POP) begin
									cnt_new = cnt_rdata - CW'(1);
								end
							end
						end
					endcase
					cnt_we    = 1'b1;
					cnt_wdata = cnt_new;
				end else begin
					cnt_new = '0;
				end
			end
			msc_pkg::ST_RESULT: begin
				if (out_load) begin
					state_nxt = msc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = msc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (state_q == msc_pkg::ST_CLEAR) begin
			clr_idx_q <= clr_idx_q + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= msc_pkg::op_t'(func);
			id_q    <= IW'(stack_id);
			id_ok_q <= id_ok;
			x_q     <= in_x[SW-1:0];
			y_q     <= in_y[SW-1:0];
		end
		if (state_q == msc_pkg::ST_COUNT) begin
			res_done_q  <= res_done;
			res_empty_q <= (cnt_new == '0);
			res_rd_q    <= ent_re;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= (state_q == msc_pkg::ST_RESULT);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && state_q == msc_pkg::ST_RESULT) begin
			out_x_q <= res_rd_q ? 16'(ent_rdata[SW-1:0]) : '0;
			out_y_q <= res_rd_q ? 16'(ent_rdata[2*SW-1:SW]) : '0;
			done_q  <= res_done_q;
			empty_q <= res_empty_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign done_res  = done_q;
	assign now_empty = empty_q;

	a_accept_to_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == msc_pkg::ST_COUNT)
		else $error("transfer did not start a count read");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msc_pkg::ST_COUNT && id_ok_q) |-> cnt_rdata <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == msc_pkg::ST_RESULT))
		else $error("result appeared without a finished item");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == msc_pkg::ST_CLEAR |-> !out_valid_q && !cnt_re)
		else $error("activity during count clearing pass");

endmodule
